[rtl/mssm_pkg.sv]
// Package for the shared-memory multi-stack core: sizes, widths,
// operation and status codes. No dependencies.
`default_nettype none
package mssm_pkg;

   localparam int NUM_STACKS   = 3;
   localparam int MAX_CAPACITY = 256;
   localparam int STORE_DEPTH  = NUM_STACKS * MAX_CAPACITY;

   localparam int DATA_W  = 32;
   localparam int OP_W    = 2;
   localparam int SEL_W   = 2;
   localparam int STAT_W  = 2;
   localparam int CAP_W   = 9;
   localparam int CNT_W   = $clog2(MAX_CAPACITY + 1);
   localparam int SIDX_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int ADDR_W  = $clog2(STORE_DEPTH);
   localparam int EXT_W   = ADDR_W + 1;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_CAPACITY);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_TOP  = 2'd2
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

endpackage
`default_nettype wire

[rtl/multi_stack_shared_memory_core.sv]
// Top level of the shared-memory multi-stack core: per-stack counts in flops,
// element storage in one synchronous single-port RAM.
// Depends on mssm_pkg.
//
// Usage: each transfer on the req_ channel pushes req_push_value onto the
// stack picked by req_stack_select, pops it, or reads its top entry. Every
// request yields exactly one transfer on the rsp_ channel carrying a status,
// the top value (read top only) and the empty/full flags after the operation.
// The stacks split the store into equal slices of the capacity set through
// csr_write_enable / csr_write_data; write it only while no request is open.
// The response is registered, valid in the cycle after the request transfer,
// when the RAM read data lands. Throughput: one request per cycle while
// rsp_ready is high; the counts update at the request edge and the RAM takes
// at most one access per request, so consecutive operations on the same stack
// need no stall. Reset clears all counts and the response valid and sets the
// capacity to its maximum; the element RAM is not cleared. When rsp_ready is
// low the response holds and req_ready drops until the response is taken.
`default_nettype none
module multi_stack_shared_memory_core (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_ready,
   input  wire  [mssm_pkg::OP_W-1:0]              req_operation,
   input  wire  [mssm_pkg::SEL_W-1:0]             req_stack_select,
   input  wire  signed [mssm_pkg::DATA_W-1:0]     req_push_value,
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output logic [mssm_pkg::STAT_W-1:0]            rsp_status,
   output logic signed [mssm_pkg::DATA_W-1:0]     rsp_top_value,
   output logic                                   rsp_now_empty,
   output logic                                   rsp_now_full,
   input  wire                                    csr_write_enable,
   input  wire  [mssm_pkg::CAP_W-1:0]             csr_write_data
);

   logic [mssm_pkg::CAP_W-1:0]   capacity_ff;
   logic [mssm_pkg::CNT_W-1:0]   cnt_ff [mssm_pkg::NUM_STACKS];
   logic [mssm_pkg::CNT_W-1:0]   cnt_in;
   logic [mssm_pkg::DATA_W-1:0]  store_mem [mssm_pkg::STORE_DEPTH];
   logic [mssm_pkg::DATA_W-1:0]  rd_data_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [mssm_pkg::STAT_W-1:0]  status_ff, status_in;
   logic                         empty_ff, empty_in;
   logic                         full_ff, full_in;
   logic                         use_rd_ff, use_rd_in;

   logic                         accept;
   logic                         sel_ok;
   logic [mssm_pkg::SIDX_W-1:0]  stack_idx;
   logic [mssm_pkg::CNT_W-1:0]   cnt_cur;
   logic [mssm_pkg::CNT_W-1:0]   cap_eff;
   logic [mssm_pkg::EXT_W-1:0]   base_addr;
   logic [mssm_pkg::EXT_W-1:0]   push_addr;
   logic [mssm_pkg::EXT_W-1:0]   top_addr;
   logic [mssm_pkg::EXT_W-1:0]   mem_addr;
   logic                         mem_wr, mem_rd;
   logic                         cnt_wr;
   mssm_pkg::op_type             op;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = mssm_pkg::CNT_W'(1);
      end else if (32'(capacity_ff) > mssm_pkg::MAX_CAPACITY) begin
         cap_eff = mssm_pkg::CNT_W'(mssm_pkg::MAX_CAPACITY);
      end else begin
         cap_eff = mssm_pkg::CNT_W'(capacity_ff);
      end
   end

   always_comb begin
      op        = mssm_pkg::op_type'(req_operation);
      sel_ok    = 32'(req_stack_select) < mssm_pkg::NUM_STACKS;
      stack_idx = mssm_pkg::SIDX_W'(req_stack_select);
      cnt_cur   = sel_ok ? cnt_ff[stack_idx] : '0;
      base_addr = mssm_pkg::EXT_W'(mssm_pkg::EXT_W'(req_stack_select)
                                   * mssm_pkg::EXT_W'(cap_eff));
      push_addr = base_addr + mssm_pkg::EXT_W'(cnt_cur);
      top_addr  = push_addr - mssm_pkg::EXT_W'(1);

      cnt_in    = cnt_cur;
      cnt_wr    = 1'b0;
      mem_wr    = 1'b0;
      mem_rd    = 1'b0;
      mem_addr  = push_addr;
      status_in = mssm_pkg::ST_OK;
      use_rd_in = 1'b0;

      if (!sel_ok) begin
         status_in = mssm_pkg::ST_EMPTY;
      end else begin
         case (op)
            mssm_pkg::OP_PUSH: begin
               if (cnt_cur >= cap_eff) begin
                  status_in = mssm_pkg::ST_FULL;
               end else begin
                  cnt_in = cnt_cur + mssm_pkg::CNT_W'(1);
                  cnt_wr = 1'b1;
                  mem_wr = 32'(push_addr) < mssm_pkg::STORE_DEPTH;
               end
            end
            mssm_pkg::OP_POP: begin
               if (cnt_cur == '0) begin
                  status_in = mssm_pkg::ST_EMPTY;
               end else begin
                  cnt_in = cnt_cur - mssm_pkg::CNT_W'(1);
                  cnt_wr = 1'b1;
               end
            end
            mssm_pkg::OP_TOP: begin
               if (cnt_cur == '0) begin
                  status_in = mssm_pkg::ST_EMPTY;
               end else begin
                  mem_addr  = top_addr;
                  mem_rd    = 32'(top_addr) < mssm_pkg::STORE_DEPTH;
                  use_rd_in = mem_rd;
               end
            end
            default: begin
            end
         endcase
      end

      empty_in     = !sel_ok || (cnt_in == '0);
      full_in      = sel_ok && (cnt_in >= cap_eff);
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= mssm_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < mssm_pkg::NUM_STACKS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (accept && cnt_wr) begin
            cnt_ff[stack_idx] <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         empty_ff  <= empty_in;
         full_ff   <= full_in;
         use_rd_ff <= use_rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && mem_wr) begin
         store_mem[mem_addr[mssm_pkg::ADDR_W-1:0]] <= req_push_value;
      end
      if (accept && mem_rd) begin
         rd_data_ff <= store_mem[mem_addr[mssm_pkg::ADDR_W-1:0]];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_top_value = use_rd_ff ? rd_data_ff : '0;
   assign rsp_now_empty = empty_ff;
   assign rsp_now_full  = full_ff;

endmodule
`default_nettype wire
